// ===== rtl/q2e_pkg.sv =====
`default_nettype none

package q2e_pkg;

  // Build constants.
  localparam int CORDIC_STEPS = 16;
  localparam int QUAT_WIDTH   = 16;

  // Internal fixed-point formats: components in Q1.20, products in Q.40.
  localparam int INT_FRAC   = 20;
  localparam int PROD_FRAC  = 2 * INT_FRAC;
  localparam int COMP_W     = INT_FRAC + 2;
  localparam int COMP_SH    = INT_FRAC - (QUAT_WIDTH - 2);
  localparam int PROD_W     = 2 * COMP_W;
  localparam int NORM_W     = PROD_W + 2;
  localparam int CORDIC_W   = PROD_W + 6;
  localparam int S30_W      = 32;
  localparam int SQRT_W     = 64;
  localparam int SQRT_STEPS = 32;
  localparam int PIPE_STEPS = SQRT_STEPS + CORDIC_STEPS;
  localparam int ANGLE_W    = 32;
  localparam int DEG_W      = 16;
  localparam int THR_W      = 16;

  localparam logic [DEG_W-1:0] TURN_UNITS = 16'd46080;
  localparam logic [THR_W-1:0] THR_RESET  = 16'd32735;

  // Register map: one register, index taken from paddr[2].
  localparam int          PADDR_W      = 3;
  localparam logic [0:0]  REG_POLE_THR = 1'b0;

  localparam logic [ANGLE_W-1:0] ANG_HALF  = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANG_NORTH = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] ANG_SOUTH = 32'hC000_0000;

  // atan(2^-i) as binary angles, 2^32 per turn.
  localparam logic [ANGLE_W-1:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic [DEG_W-1:0] pitch_deg;
    logic [DEG_W-1:0] yaw_deg;
    logic [DEG_W-1:0] roll_deg;
    pole_e            pole_case;
  } euler_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ANGLE_W-1:0]         z;
    logic                       zero;
  } cordic_t;

  typedef struct packed {
    pole_e             pole;
    cordic_t           yaw;
    cordic_t           roll;
    cordic_t           pitch;
    logic [SQRT_W-1:0] sv;
    logic [SQRT_W-1:0] sr;
  } pipe_t;

  // Sign-extends a raw component and aligns it to Q1.20.
  function automatic logic signed [COMP_W-1:0] load_comp(
    input logic signed [QUAT_WIDTH-1:0] v);
    logic signed [COMP_W-1:0] r;
    if (COMP_SH >= 0) begin
      r = COMP_W'(v) <<< COMP_SH;
    end else begin
      r = COMP_W'(v >>> (-COMP_SH));
    end
    return r;
  endfunction

  // Folds the vector into the right half plane and flags the origin.
  function automatic cordic_t cordic_pre(input logic signed [CORDIC_W-1:0] x,
                                         input logic signed [CORDIC_W-1:0] y);
    cordic_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.z = ANG_HALF;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  // One vectoring micro-rotation.
  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t n;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    n  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + ATAN_TAB[i];
    end else begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - ATAN_TAB[i];
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quaternion_to_euler_angles_unit.sv =====
// Channel     | Direction | Ports                               | Handshake
// ------------+-----------+-------------------------------------+--------------------------
// command     | in        | start, busy, quat_i                 | taken when start && !busy
// result      | out       | result_valid_o, result_o            | one-cycle strobe
// config      | in/out    | psel, penable, pwrite, paddr,       | APB, no wait states
//             |           | pwdata, prdata, pready              |
//
// One item can be taken in every cycle; busy is never raised.
// The result passes the front stages, the shared step pipe and the output stages. Most of
// the pipe is the 32-step square root that feeds the pitch arcsine, followed by its
// 16 CORDIC steps.
// Reset clears the valid bits and restores the pole threshold; no clearing pass is needed.
// The receiver cannot stall the pipeline, so a result is shown for exactly one cycle.
`default_nettype none

module quaternion_to_euler_angles_unit
  import q2e_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire quat_t              quat_i,
  output logic                    result_valid_o,
  output euler_t                  result_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Front stages (5), the shared sqrt/CORDIC pipe, then three output stages.
  localparam int LAT = 5 + PIPE_STEPS + 3;

  localparam logic signed [CORDIC_W-1:0] Q40_ONE = CORDIC_W'(1) <<< PROD_FRAC;
  localparam logic signed [S30_W+15:0]   ASIN_MAX = (S30_W+16)'(1) <<< PROD_FRAC;
  localparam logic [SQRT_W-1:0]          RAD_ONE  = 64'd1 << 60;

  // The whole datapath runs without stalls; only the valid bits and the pole threshold carry reset.
  logic              accept;
  logic [LAT-1:0]    vld_q;
  logic [THR_W-1:0]  thr_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_POLE_THR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POLE_THR) ? {16'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // Stage 1: capture the item.
  quat_t quat_q;
  always_ff @(posedge clk_i) begin
    quat_q <= quat_i;
  end

  // Stage 2: all pairwise products in Q.40.
  logic signed [COMP_W-1:0] cx, cy, cz, cw;
  logic signed [COMP_W-1:0] cx_q, cy_q;
  logic signed [PROD_W-1:0] pxx_q, pyy_q, pzz_q, pww_q, pxw_q, pyz_q;
  logic signed [PROD_W-1:0] pwy_q, pzx_q, pxy_q, pwz_q;

  assign cx = load_comp(quat_q.quat_x);
  assign cy = load_comp(quat_q.quat_y);
  assign cz = load_comp(quat_q.quat_z);
  assign cw = load_comp(quat_q.quat_w);

  always_ff @(posedge clk_i) begin
    cx_q  <= cx;
    cy_q  <= cy;
    pxx_q <= cx * cx;
    pyy_q <= cy * cy;
    pzz_q <= cz * cz;
    pww_q <= cw * cw;
    pxw_q <= cx * cw;
    pyz_q <= cy * cz;
    pwy_q <= cw * cy;
    pzx_q <= cz * cx;
    pxy_q <= cx * cy;
    pwz_q <= cw * cz;
  end

  // Stage 3: norm, pole test and the atan2 arguments for yaw and roll.
  logic [NORM_W-1:0]          norm_q;
  logic signed [NORM_W-1:0]   test_q;
  logic signed [CORDIC_W-1:0] yaw_y_q, yaw_x_q, roll_y_q, roll_x_q;
  logic signed [COMP_W-1:0]   cx3_q, cy3_q;

  always_ff @(posedge clk_i) begin
    norm_q   <= NORM_W'(pxx_q) + NORM_W'(pyy_q) + NORM_W'(pzz_q) + NORM_W'(pww_q);
    test_q   <= NORM_W'(pxw_q) - NORM_W'(pyz_q);
    yaw_y_q  <= (CORDIC_W'(pwy_q) + CORDIC_W'(pzx_q)) <<< 1;
    yaw_x_q  <= Q40_ONE - ((CORDIC_W'(pxx_q) + CORDIC_W'(pyy_q)) <<< 1);
    roll_y_q <= (CORDIC_W'(pwz_q) + CORDIC_W'(pxy_q)) <<< 1;
    roll_x_q <= Q40_ONE - ((CORDIC_W'(pzz_q) + CORDIC_W'(pxx_q)) <<< 1);
    cx3_q    <= cx_q;
    cy3_q    <= cy_q;
  end

  // Stage 4: threshold product, scaled test, and the clamped arcsine argument in Q.30.
  logic signed [63:0]         lhs_q, rhs_q;
  logic signed [S30_W+15:0]   s2;
  logic signed [S30_W+15:0]   s2_sat;
  logic signed [S30_W-1:0]    s30_q;
  logic signed [CORDIC_W-1:0] yaw_y4_q, yaw_x4_q, roll_y4_q, roll_x4_q;
  logic signed [COMP_W-1:0]   cx4_q, cy4_q;

  always_comb begin
    s2 = (S30_W+16)'(test_q) <<< 1;
    if (s2 > ASIN_MAX) begin
      s2_sat = ASIN_MAX;
    end else if (s2 < -ASIN_MAX) begin
      s2_sat = -ASIN_MAX;
    end else begin
      s2_sat = s2;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q     <= 64'(test_q) <<< 16;
    rhs_q     <= $signed({2'b00, 62'(thr_q) * 62'(norm_q)});
    s30_q     <= S30_W'(s2_sat >>> 10);
    yaw_y4_q  <= yaw_y_q;
    yaw_x4_q  <= yaw_x_q;
    roll_y4_q <= roll_y_q;
    roll_x4_q <= roll_x_q;
    cx4_q     <= cx3_q;
    cy4_q     <= cy3_q;
  end

  // Stage 5: pole decision, CORDIC folding, and the radicand 1 - s^2 in Q.60.
  pipe_t                     entry_d;
  logic signed [2*S30_W-1:0] s30_sq;

  assign s30_sq = s30_q * s30_q;

  always_comb begin
    entry_d = '0;
    if (lhs_q > rhs_q) begin
      entry_d.pole = POLE_NORTH;
    end else if (lhs_q < -rhs_q) begin
      entry_d.pole = POLE_SOUTH;
    end else begin
      entry_d.pole = POLE_NONE;
    end
    if (entry_d.pole == POLE_NONE) begin
      entry_d.yaw = cordic_pre(yaw_x4_q, yaw_y4_q);
    end else begin
      entry_d.yaw = cordic_pre(CORDIC_W'(cx4_q), CORDIC_W'(cy4_q));
    end
    entry_d.roll    = cordic_pre(roll_x4_q, roll_y4_q);
    entry_d.pitch.y = CORDIC_W'(s30_q);
    entry_d.sv      = RAD_ONE - $unsigned(s30_sq);
    entry_d.sr      = '0;
  end

  // Shared step pipe: square root digits, yaw and roll CORDIC in the first stages,
  // then the pitch CORDIC on (s, sqrt(1 - s^2)).
  pipe_t pipe_q [PIPE_STEPS+1];
  pipe_t pipe_d [PIPE_STEPS];

  for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
    localparam int BSH = (k < SQRT_STEPS) ? 62 - 2 * k : 0;
    localparam int CI  = (k < SQRT_STEPS) ? k : k - SQRT_STEPS;
    localparam logic [SQRT_W-1:0] BIT = 64'd1 << BSH;

    logic [SQRT_W-1:0] trial;
    assign trial = pipe_q[k].sr + BIT;

    always_comb begin
      pipe_d[k] = pipe_q[k];
      if (k < SQRT_STEPS) begin
        if (pipe_q[k].sv >= trial) begin
          pipe_d[k].sv = pipe_q[k].sv - trial;
          pipe_d[k].sr = (pipe_q[k].sr >> 1) + BIT;
        end else begin
          pipe_d[k].sr = pipe_q[k].sr >> 1;
        end
      end
      if (k < CORDIC_STEPS) begin
        pipe_d[k].yaw  = cordic_step(pipe_q[k].yaw, CI);
        pipe_d[k].roll = cordic_step(pipe_q[k].roll, CI);
      end
      if (k == SQRT_STEPS - 1) begin
        // The root is never negative, so no folding is needed.
        pipe_d[k].pitch.x    = CORDIC_W'(pipe_d[k].sr);
        pipe_d[k].pitch.z    = '0;
        pipe_d[k].pitch.zero = 1'b0;
      end
      if (k >= SQRT_STEPS) begin
        pipe_d[k].pitch = cordic_step(pipe_q[k].pitch, CI);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= entry_d;
    for (int k = 0; k < PIPE_STEPS; k++) begin
      pipe_q[k+1] <= pipe_d[k];
    end
  end

  // Output stage A: pick the angles for the branch taken.
  pipe_t              fin;
  logic [ANGLE_W-1:0] yaw_z, roll_z;
  logic [ANGLE_W-1:0] pitch_a_d, yaw_a_d, roll_a_d;
  logic [ANGLE_W-1:0] pitch_a_q, yaw_a_q, roll_a_q;
  pole_e              pole_a_q, pole_b_q;

  assign fin    = pipe_q[PIPE_STEPS];
  assign yaw_z  = fin.yaw.zero ? '0 : fin.yaw.z;
  assign roll_z = fin.roll.zero ? '0 : fin.roll.z;

  always_comb begin
    case (fin.pole)
      POLE_NORTH: begin
        pitch_a_d = ANG_NORTH;
        yaw_a_d   = yaw_z << 1;
        roll_a_d  = '0;
      end
      POLE_SOUTH: begin
        pitch_a_d = ANG_SOUTH;
        yaw_a_d   = '0 - (yaw_z << 1);
        roll_a_d  = '0;
      end
      default: begin
        pitch_a_d = fin.pitch.z;
        yaw_a_d   = yaw_z;
        roll_a_d  = roll_z;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pitch_a_q <= pitch_a_d;
    yaw_a_q   <= yaw_a_d;
    roll_a_q  <= roll_a_d;
    pole_a_q  <= fin.pole;
  end

  // Output stage B: binary angle to 1/128 degree, rounded half up.
  logic [47:0]      pitch_m, yaw_m, roll_m;
  logic [DEG_W-1:0] pitch_u_q, yaw_u_q, roll_u_q;

  assign pitch_m = 48'(pitch_a_q) * 48'(TURN_UNITS) + 48'h8000_0000;
  assign yaw_m   = 48'(yaw_a_q) * 48'(TURN_UNITS) + 48'h8000_0000;
  assign roll_m  = 48'(roll_a_q) * 48'(TURN_UNITS) + 48'h8000_0000;

  always_ff @(posedge clk_i) begin
    pitch_u_q <= pitch_m[47:32];
    yaw_u_q   <= yaw_m[47:32];
    roll_u_q  <= roll_m[47:32];
    pole_b_q  <= pole_a_q;
  end

  // Output stage C: a full turn after rounding wraps to zero.
  euler_t res_q;
  always_ff @(posedge clk_i) begin
    res_q.pitch_deg <= (pitch_u_q >= TURN_UNITS) ? pitch_u_q - TURN_UNITS : pitch_u_q;
    res_q.yaw_deg   <= (yaw_u_q >= TURN_UNITS) ? yaw_u_q - TURN_UNITS : yaw_u_q;
    res_q.roll_deg  <= (roll_u_q >= TURN_UNITS) ? roll_u_q - TURN_UNITS : roll_u_q;
    res_q.pole_case <= pole_b_q;
  end

  assign result_o       = res_q;
  assign result_valid_o = vld_q[LAT-1];

  // Every result traces back to a matching item taken on start.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LAT))
    else $error("result without a matching item");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.pitch_deg < TURN_UNITS) &&
                       (result_o.yaw_deg < TURN_UNITS) &&
                       (result_o.roll_deg < TURN_UNITS))
    else $error("angle out of range");

  a_pole_roll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.pole_case != POLE_NONE |-> result_o.roll_deg == '0)
    else $error("roll not zero at a pole");

  a_pole_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.pole_case == POLE_NORTH |-> result_o.pitch_deg == 16'd11520)
    else $error("north pole pitch is not 90 degrees");

endmodule

`default_nettype wire
